@@ hdl/smpf_pkg.sv @@
// Package for the sliding median position filter.
// Holds the window size, field widths, sequencer states and lane control struct.
// No dependencies.
`timescale 1ns / 1ps

package smpf_pkg;

  localparam int WINDOW      = 5;
  localparam int LAT_W       = 27;
  localparam int LON_W       = 28;
  localparam int CNT_OUT_W   = 3;
  // Both channels run through lanes of the wider field width.
  localparam int LANE_W      = (LAT_W > LON_W) ? LAT_W : LON_W;
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int IDX_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int IN_TDATA_W  = ((LAT_W + LON_W + 7) / 8) * 8;
  localparam int OUT_BITS    = LAT_W + LON_W + CNT_OUT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

  typedef logic signed [LANE_W-1:0] lane_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_POP,
    ST_CMP,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic             ins;        // write a new sample into the window
    logic             ins_shift;  // window full: drop the oldest entry
    logic [IDX_W-1:0] ins_pos;    // write position when not shifting
    logic             copy;       // copy the window into the scratch queue
    logic             pop;        // move the queue head into the holding register
    logic             cmp;        // compare holding register with the queue head
    logic [CNT_W-1:0] lim;        // active queue length during a shift
    logic             load_out;   // result is taken into the output register
    logic [CNT_W-1:0] count;      // entries in the window after insertion
  } lane_ctrl_t;

endpackage

@@ hdl/sliding_median_position_filter.sv @@
// Sliding-window median filter for latitude and longitude fixes.
// An accepted input is copied into a scratch queue, then selection passes run over m
// entries for m from n down to n/2+1, where n is the window fill after insertion.
// One item at a time; the input is ready again in the cycle after the result is
// loaded. The shared compare unit of each lane does one compare per cycle.
// Reset (rst, synchronous) empties the window.
`timescale 1ns / 1ps

module sliding_median_position_filter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // lat_sample [26:0], lon_sample [54:27], zero pad [55]
  input  logic [smpf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // lat_median [26:0], lon_median [54:27], samples_in_window [57:55], zero pad [63:58]
  output logic [smpf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import smpf_pkg::*;

  lane_ctrl_t                  ctrl;
  logic                        in_fire;
  logic                        out_free;
  logic signed [LAT_W-1:0]     lat_in;
  logic signed [LON_W-1:0]     lon_in;
  lane_word_t                  lat_lane_in;
  lane_word_t                  lon_lane_in;
  lane_word_t                  lat_cur;
  lane_word_t                  lon_cur;
  logic signed [LAT_W-1:0]     lat_median;
  logic signed [LON_W-1:0]     lon_median;
  logic [CNT_OUT_W-1:0]        samples_in_window;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign lat_in      = s_axis_tdata[LAT_W-1:0];
  assign lon_in      = s_axis_tdata[LAT_W+LON_W-1:LAT_W];
  assign lat_lane_in = LANE_W'(lat_in);
  assign lon_lane_in = LANE_W'(lon_in);

  smpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ready    (s_axis_tready),
    .ctrl     (ctrl)
  );

  smpf_lane u_lat_lane (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (lat_lane_in),
    .cur    (lat_cur)
  );

  smpf_lane u_lon_lane (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (lon_lane_in),
    .cur    (lon_cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      lat_median        <= lat_cur[LAT_W-1:0];
      lon_median        <= lon_cur[LON_W-1:0];
      samples_in_window <= CNT_OUT_W'(ctrl.count);
    end
  end

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, samples_in_window, lon_median, lat_median};

  // The sequencer takes no new item while one is being sorted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_axis_tready)
    else $error("input accepted again right after a transaction");

  // A finished result always lands in the output register.
  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |=> m_axis_tvalid)
    else $error("loaded result not presented");

  // Every result comes from a non-empty window no larger than its size.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> (ctrl.count != '0 && ctrl.count <= CNT_W'(WINDOW)))
    else $error("window fill out of range at result");

endmodule

@@ hdl/smpf_cmp_unit.sv @@
// Signed compare-and-exchange unit shared by all steps of one lane.
// Depends on smpf_pkg.
`timescale 1ns / 1ps

module smpf_cmp_unit (
  input  smpf_pkg::lane_word_t a,
  input  smpf_pkg::lane_word_t b,
  output smpf_pkg::lane_word_t lo,
  output smpf_pkg::lane_word_t hi
);
  import smpf_pkg::*;

  logic swap;

  assign swap = (a > b);
  assign lo   = swap ? b : a;
  assign hi   = swap ? a : b;

endmodule

@@ hdl/smpf_lane.sv @@
// One channel: sample window, scratch queue and the holding register of the
// selection passes. Depends on smpf_pkg and smpf_cmp_unit.
`timescale 1ns / 1ps

module smpf_lane (
  input  logic                 clk,
  input  smpf_pkg::lane_ctrl_t ctrl,
  input  smpf_pkg::lane_word_t sample,
  output smpf_pkg::lane_word_t cur
);
  import smpf_pkg::*;

  lane_word_t win [WINDOW];
  lane_word_t scr [WINDOW];
  lane_word_t lo;
  lane_word_t hi;

  smpf_cmp_unit u_cmp (
    .a  (cur),
    .b  (scr[0]),
    .lo (lo),
    .hi (hi)
  );

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      for (int k = 0; k < WINDOW; k++) begin
        if (ctrl.ins_shift) begin
          if (k == WINDOW - 1) begin
            win[k] <= sample;
          end else begin
            win[k] <= win[k + 1];
          end
        end else if (ctrl.ins_pos == IDX_W'(k)) begin
          win[k] <= sample;
        end
      end
    end
  end

  // The queue rotates toward index zero; each compare keeps the larger value
  // in the holding register and puts the smaller one at the queue tail.
  always_ff @(posedge clk) begin
    if (ctrl.copy) begin
      for (int k = 0; k < WINDOW; k++) begin
        scr[k] <= win[k];
      end
    end else if (ctrl.pop || ctrl.cmp) begin
      for (int k = 0; k < WINDOW; k++) begin
        if (CNT_W'(k) + CNT_W'(1) < ctrl.lim) begin
          if (k < WINDOW - 1) begin
            scr[k] <= scr[k + 1];
          end
        end else if (CNT_W'(k) + CNT_W'(1) == ctrl.lim && ctrl.cmp) begin
          scr[k] <= lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      cur <= scr[0];
    end else if (ctrl.cmp) begin
      cur <= hi;
    end
  end

endmodule

@@ hdl/smpf_ctrl.sv @@
// Sequencer of the filter: fill count, selection pass counters and state machine.
// Depends on smpf_pkg.
`timescale 1ns / 1ps

module smpf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 out_free,
  output logic                 ready,
  output smpf_pkg::lane_ctrl_t ctrl
);
  import smpf_pkg::*;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] fill_next;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] m;
  logic [CNT_W-1:0] j;
  logic [CNT_W-1:0] half;
  logic             full;

  assign full      = (fill == CNT_W'(WINDOW));
  assign fill_next = full ? fill : fill + CNT_W'(1);
  assign half      = n >> 1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_COPY;
      end
      ST_COPY: begin
        state_next = ST_POP;
      end
      ST_POP: begin
        // A single entry needs no compare: it is its own median.
        state_next = (m == CNT_W'(1)) ? ST_FINISH : ST_CMP;
      end
      ST_CMP: begin
        if (j == CNT_W'(1)) begin
          state_next = (m - CNT_W'(1) == half) ? ST_FINISH : ST_POP;
        end
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ready          = 1'b0;
    ctrl           = '0;
    ctrl.ins_shift = full;
    ctrl.ins_pos   = full ? IDX_W'(WINDOW - 1) : fill[IDX_W-1:0];
    ctrl.count     = n;
    ctrl.lim       = m - CNT_W'(1);
    unique case (state)
      ST_IDLE: begin
        ready    = 1'b1;
        ctrl.ins = in_fire;
      end
      ST_COPY: begin
        ctrl.copy = 1'b1;
      end
      ST_POP: begin
        ctrl.pop = 1'b1;
        ctrl.lim = m;
      end
      ST_CMP: begin
        ctrl.cmp = 1'b1;
      end
      ST_FINISH: begin
        ctrl.load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      n     <= '0;
      m     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_fire) begin
        fill <= fill_next;
        n    <= fill_next;
      end
      if (state == ST_COPY) begin
        m <= n;
      end
      if (state == ST_POP) begin
        j <= m - CNT_W'(1);
      end
      if (state == ST_CMP) begin
        j <= j - CNT_W'(1);
        if (j == CNT_W'(1)) begin
          m <= m - CNT_W'(1);
        end
      end
    end
  end

endmodule
